/* rtl/wpa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package wpa_pkg;

    localparam int CMD_BITS       = 2;
    localparam int IN_SAMPLE_BITS = 16;
    localparam int SUM_BITS       = 36;
    localparam int COUNT_BITS     = 20;
    localparam int AVG_BITS       = 24;
    localparam int FRAC_BITS      = 8;
    localparam int DIV_STEPS      = SUM_BITS + FRAC_BITS;
    localparam int DIV_CNT_BITS   = $clog2(DIV_STEPS);

    localparam logic [CMD_BITS-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_SAMPLE = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_FINISH = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_ACCUM,
        ST_DIVIDE,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic take;
        logic walk_step;
        logic accum;
        logic div_step;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic full_next;
        logic total_zero;
        logic walk_last;
        logic div_last;
    } dp_status_t;

endpackage

`default_nettype wire

/* rtl/wpa_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface wpa_in_if;

    logic                                valid;
    logic                                ready;
    logic [wpa_pkg::CMD_BITS-1:0]        command;
    logic [wpa_pkg::IN_SAMPLE_BITS-1:0]  sample_value;

    modport source (output valid, output command, output sample_value, input ready);
    modport sink   (input valid, input command, input sample_value, output ready);

endinterface

`default_nettype wire

/* rtl/wpa_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface wpa_out_if;

    logic                            valid;
    logic                            ready;
    logic                            peak_found;
    logic [wpa_pkg::COUNT_BITS-1:0]  peak_count;
    logic [wpa_pkg::AVG_BITS-1:0]    average_peak;
    logic                            average_valid;

    modport source (
        output valid, output peak_found, output peak_count,
        output average_peak, output average_valid, input ready
    );
    modport sink (
        input valid, input peak_found, input peak_count,
        input average_peak, input average_valid, output ready
    );

endinterface

`default_nettype wire

/* rtl/wpa_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module wpa_ctrl (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    input  wire logic [wpa_pkg::CMD_BITS-1:0]   in_command,
    output logic                                in_ready,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    input  wire wpa_pkg::dp_status_t            status,
    output wpa_pkg::dp_cmd_t                    cmd
);

    wpa_pkg::ctrl_state_t state_reg;
    wpa_pkg::ctrl_state_t state_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wpa_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        in_ready       = 1'b0;
        case (state_reg)
            wpa_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take = 1'b1;
                    case (in_command)
                        wpa_pkg::CMD_SAMPLE:
                            state_next = status.full_next ? wpa_pkg::ST_WALK
                                                          : wpa_pkg::ST_EMIT;
                        wpa_pkg::CMD_FINISH:
                            state_next = status.total_zero ? wpa_pkg::ST_EMIT
                                                           : wpa_pkg::ST_DIVIDE;
                        default:
                            state_next = wpa_pkg::ST_EMIT;
                    endcase
                end
            end
            wpa_pkg::ST_WALK:
            begin
                cmd.walk_step = 1'b1;
                if (status.walk_last)
                begin
                    state_next = wpa_pkg::ST_ACCUM;
                end
            end
            wpa_pkg::ST_ACCUM:
            begin
                cmd.accum  = 1'b1;
                state_next = wpa_pkg::ST_EMIT;
            end
            wpa_pkg::ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = wpa_pkg::ST_EMIT;
                end
            end
            wpa_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = wpa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = wpa_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

`ifndef ASSERT_OFF
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command at once");

    a_walk_last_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        status.walk_last |-> state_reg == wpa_pkg::ST_WALK)
        else $error("window walk ended outside the walk state");

    a_div_last_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
        status.div_last |-> state_reg == wpa_pkg::ST_DIVIDE)
        else $error("divider finished outside the divide state");

    a_load_shows_word: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg)
        else $error("loaded result word not offered");
`endif

endmodule

`default_nettype wire

/* rtl/wpa_dpath.sv */
`timescale 1ns / 1ps
`default_nettype none

module wpa_dpath #(
    parameter int WINDOW      = 15,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire wpa_pkg::dp_cmd_t                     cmd,
    output wpa_pkg::dp_status_t                       status,
    input  wire logic [wpa_pkg::CMD_BITS-1:0]         in_command,
    input  wire logic [wpa_pkg::IN_SAMPLE_BITS-1:0]   in_sample,
    output logic                                      out_peak_found,
    output logic [wpa_pkg::COUNT_BITS-1:0]            out_peak_count,
    output logic [wpa_pkg::AVG_BITS-1:0]              out_average_peak,
    output logic                                      out_average_valid
);

    localparam int PW      = $clog2(WINDOW);
    localparam int FW      = $clog2(WINDOW + 1);
    localparam int SB      = wpa_pkg::SUM_BITS;
    localparam int CB      = wpa_pkg::COUNT_BITS;
    localparam int AB      = wpa_pkg::AVG_BITS;
    localparam int DB      = wpa_pkg::DIV_STEPS;
    localparam int DCB     = wpa_pkg::DIV_CNT_BITS;

    localparam logic [PW-1:0]  LAST_IDX   = PW'(WINDOW - 1);
    localparam logic [PW-1:0]  HALF_IDX   = PW'(WINDOW / 2);
    localparam logic [FW-1:0]  FILL_FULL  = FW'(WINDOW);
    localparam logic [FW-1:0]  FILL_ALMOST = FW'(WINDOW - 1);
    localparam logic [SB-1:0]  SUM_MAX    = '1;
    localparam logic [CB-1:0]  TOTAL_MAX  = '1;
    localparam logic [AB-1:0]  AVG_MAX    = '1;
    localparam logic [DCB-1:0] DIV_LAST   = DCB'(DB - 1);

    logic [SAMPLE_BITS-1:0] mem [WINDOW];

    // control state
    logic [PW-1:0]  wpos_reg, wpos_next;
    logic [FW-1:0]  fill_reg, fill_next;
    logic [SB-1:0]  sum_reg, sum_next;
    logic [CB-1:0]  total_reg, total_next;
    logic [FW-1:0]  issue_reg, issue_next;
    logic           rv_reg, rv_next;
    logic [PW-1:0]  ridx_reg, ridx_next;
    logic [DCB-1:0] div_cnt_reg, div_cnt_next;

    // payload
    logic [PW-1:0]          rd_addr_reg;
    logic [SAMPLE_BITS-1:0] rd_data_reg;
    logic [SAMPLE_BITS-1:0] prev_reg;
    logic [SAMPLE_BITS-1:0] centre_reg;
    logic                   ok_reg;
    logic [CB-1:0]          rem_reg;
    logic [DB-1:0]          quo_reg;
    logic                   item_found_reg;
    logic [AB-1:0]          item_avg_reg;
    logic                   item_fin_reg;

    logic [SAMPLE_BITS-1:0] sample_w;
    logic [PW-1:0]          wpos_step;
    logic [PW-1:0]          rd_addr_step;
    logic                   issuing;
    logic                   pair_fail;
    logic [SB:0]            sum_add;
    logic [CB:0]            rem_sh;
    logic                   rem_ge;
    logic [CB-1:0]          rem_new;
    logic [DB-1:0]          quo_new;
    logic [AB-1:0]          quo_sat;

    always_comb
    begin
        sample_w     = SAMPLE_BITS'(in_sample);
        wpos_step    = (wpos_reg == LAST_IDX) ? '0 : wpos_reg + 1'b1;
        rd_addr_step = (rd_addr_reg == LAST_IDX) ? '0 : rd_addr_reg + 1'b1;
        issuing      = issue_reg < FILL_FULL;

        // rising side up to the centre, falling side after it
        pair_fail = (ridx_reg != '0) &&
                    (((ridx_reg <= HALF_IDX) && (prev_reg > rd_data_reg)) ||
                     ((ridx_reg > HALF_IDX) && (prev_reg < rd_data_reg)));

        sum_add = {1'b0, sum_reg} + (SB + 1)'(centre_reg);

        // restoring division, one quotient bit per step
        rem_sh  = {rem_reg, quo_reg[DB-1]};
        rem_ge  = rem_sh >= {1'b0, total_reg};
        rem_new = rem_ge ? CB'(rem_sh - {1'b0, total_reg}) : rem_sh[CB-1:0];
        quo_new = {quo_reg[DB-2:0], rem_ge};
        quo_sat = (quo_new[DB-1:AB] != '0) ? AVG_MAX : quo_new[AB-1:0];

        status.full_next  = fill_reg >= FILL_ALMOST;
        status.total_zero = total_reg == '0;
        status.walk_last  = rv_reg && (ridx_reg == LAST_IDX);
        status.div_last   = div_cnt_reg == DIV_LAST;

        wpos_next    = wpos_reg;
        fill_next    = fill_reg;
        sum_next     = sum_reg;
        total_next   = total_reg;
        issue_next   = issue_reg;
        rv_next      = 1'b0;
        ridx_next    = ridx_reg;
        div_cnt_next = div_cnt_reg;

        if (cmd.take)
        begin
            case (in_command)
                wpa_pkg::CMD_CLEAR:
                begin
                    wpos_next  = '0;
                    fill_next  = '0;
                    sum_next   = '0;
                    total_next = '0;
                end
                wpa_pkg::CMD_SAMPLE:
                begin
                    wpos_next  = wpos_step;
                    fill_next  = (fill_reg == FILL_FULL) ? fill_reg : fill_reg + 1'b1;
                    issue_next = '0;
                end
                wpa_pkg::CMD_FINISH:
                begin
                    div_cnt_next = '0;
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.walk_step)
        begin
            rv_next = issuing;
            if (issuing)
            begin
                issue_next = issue_reg + 1'b1;
                ridx_next  = issue_reg[PW-1:0];
            end
        end

        if (cmd.accum && ok_reg)
        begin
            sum_next   = sum_add[SB] ? SUM_MAX : sum_add[SB-1:0];
            total_next = (total_reg == TOTAL_MAX) ? total_reg : total_reg + 1'b1;
        end

        if (cmd.div_step)
        begin
            div_cnt_next = status.div_last ? '0 : div_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wpos_reg    <= '0;
            fill_reg    <= '0;
            sum_reg     <= '0;
            total_reg   <= '0;
            issue_reg   <= '0;
            rv_reg      <= 1'b0;
            ridx_reg    <= '0;
            div_cnt_reg <= '0;
        end
        else
        begin
            wpos_reg    <= wpos_next;
            fill_reg    <= fill_next;
            sum_reg     <= sum_next;
            total_reg   <= total_next;
            issue_reg   <= issue_next;
            rv_reg      <= rv_next;
            ridx_reg    <= ridx_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    // ring memory, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (cmd.take && (in_command == wpa_pkg::CMD_SAMPLE))
        begin
            mem[wpos_reg] <= sample_w;
        end
        if (cmd.walk_step && issuing)
        begin
            rd_data_reg <= mem[rd_addr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            item_found_reg <= 1'b0;
            item_avg_reg   <= '0;
            item_fin_reg   <= in_command == wpa_pkg::CMD_FINISH;
            rd_addr_reg    <= wpos_step;
            ok_reg         <= 1'b1;
            rem_reg        <= '0;
            quo_reg        <= {sum_reg, {wpa_pkg::FRAC_BITS{1'b0}}};
        end
        if (cmd.walk_step)
        begin
            if (issuing)
            begin
                rd_addr_reg <= rd_addr_step;
            end
            if (rv_reg)
            begin
                prev_reg <= rd_data_reg;
                if (pair_fail)
                begin
                    ok_reg <= 1'b0;
                end
                if (ridx_reg == HALF_IDX)
                begin
                    centre_reg <= rd_data_reg;
                end
            end
        end
        if (cmd.accum && ok_reg)
        begin
            item_found_reg <= 1'b1;
        end
        if (cmd.div_step)
        begin
            rem_reg <= rem_new;
            quo_reg <= quo_new;
            if (status.div_last)
            begin
                item_avg_reg <= quo_sat;
            end
        end
        if (cmd.out_load)
        begin
            out_peak_found    <= item_found_reg;
            out_peak_count    <= total_reg;
            out_average_peak  <= item_avg_reg;
            out_average_valid <= item_fin_reg;
        end
    end

`ifndef ASSERT_OFF
    a_walk_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        status.walk_last |-> fill_reg == FILL_FULL)
        else $error("peak test on a ring that is not full");

    a_accum_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accum |=> (total_reg >= $past(total_reg)) && (sum_reg >= $past(sum_reg)))
        else $error("peak sum or count went down");

    a_clear_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.take && (in_command == wpa_pkg::CMD_CLEAR)) |=>
            (total_reg == '0) && (fill_reg == '0) && (sum_reg == '0))
        else $error("clear left state behind");
`endif

endmodule

`default_nettype wire

/* rtl/window_peak_averager.sv */
// path: a sample that fills the ring, or comes once it is full, takes the window walk
// (one memory read per cycle), then the peak update; other samples, clear and unused
// codes go straight to the output; finish with a nonzero count takes the 44-step
// restoring divider first, else it goes straight out; one word is in work at a time
// rst_n is asynchronous and active low and clears ring pointers, fill, sum and count
`timescale 1ns / 1ps
`default_nettype none

module window_peak_averager #(
    parameter int WINDOW      = 15,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    wpa_in_if.sink       samples,
    wpa_out_if.source    results
);

    wpa_pkg::dp_cmd_t    cmd;
    wpa_pkg::dp_status_t status;

    wpa_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (samples.valid),
        .in_command (samples.command),
        .in_ready   (samples.ready),
        .out_valid  (results.valid),
        .out_ready  (results.ready),
        .status     (status),
        .cmd        (cmd)
    );

    wpa_dpath #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dpath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .in_command        (samples.command),
        .in_sample         (samples.sample_value),
        .out_peak_found    (results.peak_found),
        .out_peak_count    (results.peak_count),
        .out_average_peak  (results.average_peak),
        .out_average_valid (results.average_valid)
    );

endmodule

`default_nettype wire

/* verif/window_peak_averager_test.sv */
`timescale 1ns / 1ps

module window_peak_averager_test;

    localparam int WINDOW_LEN = 15;
    localparam int HALF_LEN = WINDOW_LEN / 2;
    localparam int WORD_TARGET = 1350;
    localparam logic [wpa_pkg::CMD_BITS-1:0] CMD_UNUSED = 2'd3;
    localparam logic [wpa_pkg::SUM_BITS-1:0] SUM_LIMIT = {wpa_pkg::SUM_BITS{1'b1}};
    localparam logic [wpa_pkg::COUNT_BITS-1:0] COUNT_LIMIT = {wpa_pkg::COUNT_BITS{1'b1}};
    localparam logic [wpa_pkg::AVG_BITS-1:0] AVG_LIMIT = {wpa_pkg::AVG_BITS{1'b1}};

    typedef logic [wpa_pkg::CMD_BITS-1:0] command_t;
    typedef logic [wpa_pkg::IN_SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        logic                           peak_found;
        logic [wpa_pkg::COUNT_BITS-1:0] peak_count;
        logic [wpa_pkg::AVG_BITS-1:0]   average_peak;
        logic                           average_valid;
    } result_word_t;

    class peak_ledger;
        sample_t                        ring [WINDOW_LEN];
        int unsigned                    slot;
        int unsigned                    held;
        logic [wpa_pkg::SUM_BITS-1:0]   sum;
        logic [wpa_pkg::COUNT_BITS-1:0] total;
        result_word_t                   awaited [$];
        int unsigned                    mismatches;

        function void clear_state();
            foreach (ring[i])
                ring[i] = '0;
            slot = 0;
            held = 0;
            sum = '0;
            total = '0;
        endfunction

        function bit centre_is_peak(int unsigned oldest);
            for (int i = 0; i < HALF_LEN; i++)
                if (ring[(oldest + i) % WINDOW_LEN] > ring[(oldest + i + 1) % WINDOW_LEN])
                    return 1'b0;
            for (int i = HALF_LEN; i + 1 < WINDOW_LEN; i++)
                if (ring[(oldest + i) % WINDOW_LEN] < ring[(oldest + i + 1) % WINDOW_LEN])
                    return 1'b0;
            return 1'b1;
        endfunction

        function logic [wpa_pkg::AVG_BITS-1:0] average_q8();
            logic [wpa_pkg::SUM_BITS+wpa_pkg::FRAC_BITS-1:0] quotient;
            if (total == '0)
                return '0;
            quotient = {sum, {wpa_pkg::FRAC_BITS{1'b0}}} / total;
            if (quotient > AVG_LIMIT)
                return AVG_LIMIT;
            return quotient[wpa_pkg::AVG_BITS-1:0];
        endfunction

        function void note_word(command_t cmd, sample_t value);
            result_word_t                 r;
            int unsigned                  oldest;
            logic [wpa_pkg::SUM_BITS-1:0] centre;
            r = '0;
            case (cmd)
                wpa_pkg::CMD_CLEAR:
                    clear_state();
                wpa_pkg::CMD_SAMPLE:
                begin
                    ring[slot] = value;
                    if (held < WINDOW_LEN)
                        held++;
                    if (held >= WINDOW_LEN)
                    begin
                        oldest = (slot + 1) % WINDOW_LEN;
                        if (centre_is_peak(oldest))
                        begin
                            centre = {{(wpa_pkg::SUM_BITS - wpa_pkg::IN_SAMPLE_BITS){1'b0}},
                                      ring[(oldest + HALF_LEN) % WINDOW_LEN]};
                            r.peak_found = 1'b1;
                            sum = (SUM_LIMIT - sum < centre) ? SUM_LIMIT : sum + centre;
                            if (total < COUNT_LIMIT)
                                total++;
                        end
                    end
                    slot = (slot + 1) % WINDOW_LEN;
                end
                wpa_pkg::CMD_FINISH:
                begin
                    r.average_peak = average_q8();
                    r.average_valid = 1'b1;
                end
                default:
                    ;
            endcase
            r.peak_count = total;
            awaited.push_back(r);
        endfunction

        function void check_word(result_word_t got);
            result_word_t want;
            if (awaited.size() == 0)
            begin
                $error("result word with nothing awaited");
                mismatches++;
                return;
            end
            want = awaited.pop_front();
            if (got.peak_found !== want.peak_found)
            begin
                $error("peak_found: expected %0d, actual %0d", want.peak_found, got.peak_found);
                mismatches++;
            end
            if (got.peak_count !== want.peak_count)
            begin
                $error("peak_count: expected %0d, actual %0d", want.peak_count, got.peak_count);
                mismatches++;
            end
            if (got.average_peak !== want.average_peak)
            begin
                $error("average_peak: expected %0d, actual %0d",
                       want.average_peak, got.average_peak);
                mismatches++;
            end
            if (got.average_valid !== want.average_valid)
            begin
                $error("average_valid: expected %0d, actual %0d",
                       want.average_valid, got.average_valid);
                mismatches++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    wpa_in_if  samples_if ();
    wpa_out_if results_if ();

    window_peak_averager #(
        .WINDOW      (WINDOW_LEN),
        .SAMPLE_BITS (wpa_pkg::IN_SAMPLE_BITS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_if),
        .results (results_if)
    );

    peak_ledger  ledger = new();
    int unsigned sent_words = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    always @(posedge clk)
        results_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && results_if.valid && results_if.ready)
            ledger.check_word({results_if.peak_found, results_if.peak_count,
                               results_if.average_peak, results_if.average_valid});
    end

    task automatic send_word(input command_t cmd, input sample_t value);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            samples_if.valid <= 1'b0;
            @(posedge clk);
        end
        samples_if.valid <= 1'b1;
        samples_if.command <= cmd;
        samples_if.sample_value <= value;
        @(posedge clk);
        while (!samples_if.ready)
            @(posedge clk);
        ledger.note_word(cmd, value);
        sent_words++;
    endtask

    // rise to a top and fall away, sometimes with one sample of the rise, the fall or both knocked out of order
    task automatic send_mountain();
        int unsigned top;
        int unsigned rise_len;
        int unsigned fall_len;
        int unsigned rise [$];
        int unsigned fall [$];
        case ($urandom_range(0, 3))
            0:       top = $urandom_range(0, 3);
            1:       top = 16'hFFFF;
            default: top = $urandom_range(0, 16'hFFFF);
        endcase
        rise_len = $urandom_range(7, 11);
        fall_len = $urandom_range(7, 11);
        for (int i = 0; i < rise_len; i++)
            rise.push_back($urandom_range(0, top));
        for (int i = 0; i < fall_len; i++)
            fall.push_back($urandom_range(0, top));
        rise.sort();
        fall.rsort();
        if ($urandom_range(0, 99) < 20)
            rise[$urandom_range(0, rise_len - 1)] = $urandom_range(0, 16'hFFFF);
        if ($urandom_range(0, 99) < 10)
            fall[$urandom_range(0, fall_len - 1)] = $urandom_range(0, 16'hFFFF);
        foreach (rise[i])
            send_word(wpa_pkg::CMD_SAMPLE, sample_t'(rise[i]));
        send_word(wpa_pkg::CMD_SAMPLE, sample_t'(top));
        foreach (fall[i])
            send_word(wpa_pkg::CMD_SAMPLE, sample_t'(fall[i]));
    endtask

    task automatic send_noise();
        int unsigned count;
        count = $urandom_range(1, 10);
        repeat (count)
            send_word(wpa_pkg::CMD_SAMPLE, sample_t'($urandom_range(0, 16'hFFFF)));
    endtask

    task automatic run_random(input int unsigned target);
        int unsigned pick;
        while (sent_words < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                send_mountain();
            else if (pick < 72)
                send_noise();
            else if (pick < 84)
                send_word(wpa_pkg::CMD_FINISH, sample_t'($urandom_range(0, 16'hFFFF)));
            else if (pick < 92)
                send_word(CMD_UNUSED, sample_t'($urandom_range(0, 16'hFFFF)));
            else
                send_word(wpa_pkg::CMD_CLEAR, sample_t'($urandom_range(0, 16'hFFFF)));
        end
    endtask

    sample_t hill [WINDOW_LEN] = '{
        16'h0000, 16'h0001, 16'h0001, 16'h00FF, 16'h1234, 16'h8000, 16'hFFFE, 16'hFFFF,
        16'hFFFF, 16'h8001, 16'h0100, 16'h0100, 16'h0002, 16'h0000, 16'h0000
    };

    initial
    begin
        int unsigned base;
        ledger.clear_state();
        ledger.mismatches = 0;
        rst_n <= 1'b0;
        samples_if.valid <= 1'b0;
        samples_if.command <= wpa_pkg::CMD_CLEAR;
        samples_if.sample_value <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty average, unused code, one clean peak at full scale
        send_word(wpa_pkg::CMD_CLEAR, 16'hFFFF);
        send_word(wpa_pkg::CMD_FINISH, 16'h0000);
        send_word(CMD_UNUSED, 16'hFFFF);
        foreach (hill[i])
            send_word(wpa_pkg::CMD_SAMPLE, hill[i]);
        send_word(wpa_pkg::CMD_FINISH, 16'hA5A5);
        send_word(CMD_UNUSED, 16'h0000);
        send_word(wpa_pkg::CMD_SAMPLE, 16'h0000);
        send_word(wpa_pkg::CMD_FINISH, 16'h5A5A);

        base = sent_words;
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 82; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 82; end
                default: begin send_idle_pct = 35; recv_stall_pct = 35; end
            endcase
            run_random(base + (phase + 1) * WORD_TARGET / 4);
        end
        samples_if.valid <= 1'b0;

        while (ledger.awaited.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (ledger.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
